// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form with an explicit clock and active-low reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Short form on the standard clk_i / rst_ni pair.
`define ASSERT_STD(name, prop, msg) \
  `ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ----- design/lzss_pkg.sv -----
// ----------------------------------------------------------------------------
// lzss_pkg
// Sizes and types of the LZSS bit stream decompressor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzss_pkg;

  localparam int unsigned PosBits  = 12;
  localparam int unsigned LenBits  = 4;
  localparam int unsigned LitBits  = 8;
  localparam int unsigned MinMatch = 2;
  localparam int unsigned WinDepth = 1 << PosBits;
  localparam int unsigned CntW     = $clog2(PosBits + 1);
  localparam int unsigned RunW     = LenBits + 1;
  localparam int unsigned LeftW    = $clog2(LitBits + 1);

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [LitBits-1:0] byte_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [RunW-1:0]    run_t;
  typedef logic [LeftW-1:0]   left_t;

endpackage

// ----- design/lzss_bitstream_decompressor_core.sv -----
// ----------------------------------------------------------------------------
// lzss_bitstream_decompressor_core
// LZSS decompressor with a 4096-byte history window held in one memory.
// ----------------------------------------------------------------------------
// An input beat is accepted, then parsed one bit per cycle, held while a parsed
// literal or end marker waits for the output. A completed match then copies one
// byte per cycle (2 to 17) while the output is free; no new beat is taken meanwhile.
// Window entries never written read as zero through a fill mark on the write
// pointer, so no clearing pass runs after reset. After the end marker every
// input beat is accepted and dropped until reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzss_bitstream_decompressor_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 byte_valid_o,
  output logic                 last_of_run_o,
  output logic                 stream_end_o
);

  typedef enum logic [1:0] {S_IDLE, S_BITS, S_COPY, S_DONE} state_e;
  typedef enum logic [1:0] {PH_FLAG, PH_LIT, PH_POS, PH_LEN} phase_e;

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  lzss_pkg::pos_t   acc_q, acc_d;
  lzss_pkg::cnt_t   cnt_q, cnt_d;
  lzss_pkg::pos_t   wp_q, wp_d;
  logic             full_q, full_d;
  lzss_pkg::byte_t  byte_q, byte_d;
  lzss_pkg::left_t  left_q, left_d;
  lzss_pkg::pos_t   pos_q, pos_d;
  lzss_pkg::run_t   remain_q, remain_d;
  lzss_pkg::pos_t   rd_ptr_q, rd_ptr_d;
  logic             out_valid_q, out_valid_d;
  lzss_pkg::byte_t  out_byte_q, out_byte_d;
  logic             out_bv_q, out_bv_d;
  logic             out_last_q, out_last_d;
  logic             out_end_q, out_end_d;

  lzss_pkg::byte_t  win_mem [lzss_pkg::WinDepth];
  lzss_pkg::byte_t  rdata_q;
  lzss_pkg::byte_t  fwd_data_q;
  logic             fwd_q;
  logic             ok_q;

  logic             mem_we;
  logic             mem_re;
  lzss_pkg::pos_t   mem_raddr;
  lzss_pkg::byte_t  mem_wdata;
  logic             rd_ok;

  logic             bit_w;
  logic             take;
  logic             out_free;
  lzss_pkg::pos_t   acc_sh;
  lzss_pkg::cnt_t   cnt_inc;
  lzss_pkg::run_t   len_count;
  lzss_pkg::pos_t   wp_inc;
  lzss_pkg::pos_t   rd_next;
  lzss_pkg::left_t  left_dec;
  lzss_pkg::byte_t  copy_val;

  assign bit_w     = byte_q[lzss_pkg::LitBits-1];
  assign acc_sh    = {acc_q[lzss_pkg::PosBits-2:0], bit_w};
  assign cnt_inc   = cnt_q + 1'b1;
  assign len_count = lzss_pkg::run_t'(acc_sh[lzss_pkg::LenBits-1:0])
                   + lzss_pkg::run_t'(lzss_pkg::MinMatch);
  assign wp_inc    = wp_q + 1'b1;
  assign rd_next   = rd_ptr_q + 1'b1;
  assign left_dec  = left_q - 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;
  assign copy_val  = fwd_q ? fwd_data_q : (ok_q ? rdata_q : '0);
  assign in_ready_o = (state_q == S_IDLE) || (state_q == S_DONE);

  assign rd_ok = full_q || ((mem_raddr != '0) && ((mem_raddr < wp_q) || (wp_q == '0)));

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    wp_d        = wp_q;
    full_d      = full_q;
    byte_d      = byte_q;
    left_d      = left_q;
    pos_d       = pos_q;
    remain_d    = remain_q;
    rd_ptr_d    = rd_ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_bv_d    = out_bv_q;
    out_last_d  = out_last_q;
    out_end_d   = out_end_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_q;
    mem_wdata   = copy_val;
    take        = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          byte_d  = in_byte_i;
          left_d  = lzss_pkg::left_t'(lzss_pkg::LitBits);
          state_d = S_BITS;
        end
      end
      S_BITS: begin
        case (phase_q)
          PH_FLAG: begin
            phase_d = bit_w ? PH_LIT : PH_POS;
            acc_d   = '0;
            cnt_d   = '0;
          end
          PH_LIT: begin
            if (cnt_inc == lzss_pkg::cnt_t'(lzss_pkg::LitBits)) begin
              if (out_free) begin
                out_valid_d = 1'b1;
                out_byte_d  = acc_sh[lzss_pkg::LitBits-1:0];
                out_bv_d    = 1'b1;
                out_last_d  = 1'b1;
                out_end_d   = 1'b0;
                mem_we      = 1'b1;
                mem_wdata   = acc_sh[lzss_pkg::LitBits-1:0];
                phase_d     = PH_FLAG;
              end else begin
                take = 1'b0;
              end
            end else begin
              acc_d = acc_sh;
              cnt_d = cnt_inc;
            end
          end
          PH_POS: begin
            if (cnt_inc == lzss_pkg::cnt_t'(lzss_pkg::PosBits)) begin
              if (acc_sh == '0) begin
                if (out_free) begin
                  out_valid_d = 1'b1;
                  out_byte_d  = '0;
                  out_bv_d    = 1'b0;
                  out_last_d  = 1'b1;
                  out_end_d   = 1'b1;
                  phase_d     = PH_FLAG;
                  state_d     = S_DONE;
                end else begin
                  take = 1'b0;
                end
              end else begin
                pos_d   = acc_sh;
                acc_d   = '0;
                cnt_d   = '0;
                phase_d = PH_LEN;
              end
            end else begin
              acc_d = acc_sh;
              cnt_d = cnt_inc;
            end
          end
          PH_LEN: begin
            if (cnt_inc == lzss_pkg::cnt_t'(lzss_pkg::LenBits)) begin
              mem_re    = 1'b1;
              mem_raddr = pos_q;
              rd_ptr_d  = pos_q;
              remain_d  = len_count;
              phase_d   = PH_FLAG;
              state_d   = S_COPY;
            end else begin
              acc_d = acc_sh;
              cnt_d = cnt_inc;
            end
          end
          default: begin
            phase_d = PH_FLAG;
          end
        endcase
        if (take) begin
          byte_d = byte_q << 1;
          left_d = left_dec;
          if ((state_d == S_BITS) && (left_dec == '0)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_COPY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = copy_val;
          out_bv_d    = 1'b1;
          out_last_d  = (remain_q == lzss_pkg::run_t'(1));
          out_end_d   = 1'b0;
          mem_we      = 1'b1;
          mem_wdata   = copy_val;
          remain_d    = remain_q - 1'b1;
          if (remain_q != lzss_pkg::run_t'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = rd_next;
            rd_ptr_d  = rd_next;
          end else begin
            state_d = (left_q != '0) ? S_BITS : S_IDLE;
          end
        end
      end
      S_DONE: begin
        state_d = S_DONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (mem_we) begin
      wp_d = wp_inc;
      if (wp_q == '0) begin
        full_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FLAG;
      acc_q       <= '0;
      cnt_q       <= '0;
      wp_q        <= lzss_pkg::pos_t'(1);
      full_q      <= 1'b0;
      byte_q      <= '0;
      left_q      <= '0;
      pos_q       <= '0;
      remain_q    <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_bv_q    <= 1'b0;
      out_last_q  <= 1'b0;
      out_end_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      full_q      <= full_d;
      byte_q      <= byte_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      remain_q    <= remain_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_bv_q    <= out_bv_d;
      out_last_q  <= out_last_d;
      out_end_q   <= out_end_d;
    end
  end

  // A read of the entry written in the same cycle takes the new byte from the bypass.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[wp_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q    <= win_mem[mem_raddr];
      fwd_q      <= mem_we && (mem_raddr == wp_q);
      fwd_data_q <= mem_wdata;
      ok_q       <= rd_ok;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = out_bv_q;
  assign last_of_run_o = out_last_q;
  assign stream_end_o  = out_end_q;

  `ASSERT_STD(a_copy_has_work, (state_q == S_COPY) |-> (remain_q != '0),
              "copy running with no bytes left")
  `ASSERT_STD(a_end_beat_shape, (out_valid_o && stream_end_o) |-> (last_of_run_o && !byte_valid_o),
              "end marker beat carries data or is not last")
  `ASSERT_STD(a_wp_step, mem_we |=> (wp_q == $past(wp_inc)),
              "write pointer did not advance by one on a window write")
  `ASSERT_STD(a_done_sticks, (state_q == S_DONE) |=> (state_q == S_DONE),
              "left the end state without reset")

endmodule
